### rtl/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared constants, types and byte functions of the serial frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

    // Payload size in bytes (1 to 255)
    localparam int PAYLOAD_SIZE = 16;

    // Framing bytes
    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] NL_CHAR    = 8'h0A;
    localparam logic [7:0] MSG_TYPE_RST = 8'd65;

    // Header length in bytes
    localparam int HDR_LEN = 9;

    // Widths
    localparam int PAY_IDX_W = (PAYLOAD_SIZE > 1) ? $clog2(PAYLOAD_SIZE) : 1;
    localparam int FILL_W    = $clog2(PAYLOAD_SIZE + 1);
    localparam int HDR_IDX_W = $clog2(HDR_LEN);
    localparam int CNT_W     = (FILL_W > HDR_IDX_W) ? FILL_W : HDR_IDX_W;

    localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HDR_LEN - 1);
    localparam logic [CNT_W-1:0] PAY_LAST = CNT_W'(PAYLOAD_SIZE - 1);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(PAYLOAD_SIZE - 1);

    // Source of the next frame byte
    typedef enum logic [2:0] {
        SRC_FLAG,
        SRC_HDR,
        SRC_ESC,
        SRC_PAY,
        SRC_PAY_X,
        SRC_CRC_LO,
        SRC_CRC_HI
    } t_src;

    // Controller to datapath
    typedef struct packed {
        logic             store_wr;
        logic             load;
        t_src             sel;
        logic             frame_end;
        logic             crc_clr;
        logic             crc_upd;
        logic             clr_fill;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic flush;
        logic pay_esc;
        logic out_free;
    } t_sts;

    // Header byte at a given position
    function automatic logic [7:0] hdr_byte(input logic [CNT_W-1:0] idx,
                                            input logic [7:0] msg_type);
        logic [7:0] b;
        unique case (idx)
            CNT_W'(0): b = 8'h45;
            CNT_W'(2): b = 8'hFF;
            CNT_W'(3): b = 8'hFF;
            CNT_W'(6): b = 8'(PAYLOAD_SIZE);
            CNT_W'(8): b = msg_type;
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

    // One byte step of CRC-16 CCITT (poly 0x1021)
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]};
        c = c ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

### rtl/sfb_ctrl.sv
// ----------------------------------------------------------------------------
// sfb_ctrl
// Frame sequencer: accepts characters and walks the frame byte by byte.
// ----------------------------------------------------------------------------
module sfb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sfb_pkg::t_sts i_sts,
    output sfb_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_HDR,
        S_PAY,
        S_PAYX,
        S_CRCL,
        S_CRCH,
        S_END
    } t_state;

    t_state                     r_state, n_state;
    logic [sfb_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic                       pay_last;

    assign pay_last = (r_idx == sfb_pkg::PAY_LAST);

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        o_in_ready       = 1'b0;
        o_cmd.store_wr   = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.sel        = sfb_pkg::SRC_FLAG;
        o_cmd.frame_end  = 1'b0;
        o_cmd.crc_clr    = 1'b0;
        o_cmd.crc_upd    = 1'b0;
        o_cmd.clr_fill   = 1'b0;
        o_cmd.idx        = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.store_wr = i_in_valid;
                if (i_in_valid && i_sts.flush) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.sel     = sfb_pkg::SRC_FLAG;
                    o_cmd.crc_clr = 1'b1;
                    n_idx         = '0;
                    n_state       = S_HDR;
                end
            end
            S_HDR: begin
                if (i_sts.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.sel     = sfb_pkg::SRC_HDR;
                    o_cmd.crc_upd = 1'b1;
                    if (r_idx == sfb_pkg::HDR_LAST) begin
                        n_idx   = '0;
                        n_state = S_PAY;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_PAY: begin
                if (i_sts.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.crc_upd = 1'b1;
                    if (i_sts.pay_esc) begin
                        o_cmd.sel = sfb_pkg::SRC_ESC;
                        n_state   = S_PAYX;
                    end else begin
                        o_cmd.sel = sfb_pkg::SRC_PAY;
                        if (pay_last) begin
                            n_state = S_CRCL;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end
            end
            S_PAYX: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = sfb_pkg::SRC_PAY_X;
                    if (pay_last) begin
                        n_state = S_CRCL;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_PAY;
                    end
                end
            end
            S_CRCL: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = sfb_pkg::SRC_CRC_LO;
                    n_state    = S_CRCH;
                end
            end
            S_CRCH: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = sfb_pkg::SRC_CRC_HI;
                    n_state    = S_END;
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.sel       = sfb_pkg::SRC_FLAG;
                    o_cmd.frame_end = 1'b1;
                    o_cmd.clr_fill  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

### rtl/sfb_dp.sv
// ----------------------------------------------------------------------------
// sfb_dp
// Datapath: payload store, fill, message type, CRC and output registers.
// ----------------------------------------------------------------------------
module sfb_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfb_pkg::t_cmd i_cmd,
    output sfb_pkg::t_sts o_sts,
    input  logic [7:0]    i_char_in,
    input  logic          i_cfg_wr_en,
    input  logic [7:0]    i_cfg_wr_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_byte_out,
    output logic          o_frame_end
);

    logic [7:0]                 r_store [sfb_pkg::PAYLOAD_SIZE];
    logic [sfb_pkg::FILL_W-1:0] r_fill;
    logic [7:0]                 r_msg_type;
    logic [15:0]                r_crc;
    logic                       r_out_valid;
    logic [7:0]                 r_byte;
    logic                       r_end;

    logic [7:0] pay_byte;
    logic [7:0] hdr;
    logic [7:0] crc_in;
    logic [7:0] n_byte;

    // Stored byte at the frame index, zero past the fill count
    always_comb begin
        if (i_cmd.idx < sfb_pkg::CNT_W'(r_fill)) begin
            pay_byte = r_store[i_cmd.idx[sfb_pkg::PAY_IDX_W-1:0]];
        end else begin
            pay_byte = 8'h00;
        end
    end

    assign hdr    = sfb_pkg::hdr_byte(i_cmd.idx, r_msg_type);
    assign crc_in = (i_cmd.sel == sfb_pkg::SRC_HDR) ? hdr : pay_byte;

    // Status toward the sequencer
    assign o_sts.flush    = (r_fill == sfb_pkg::FILL_LAST) || (i_char_in == sfb_pkg::NL_CHAR);
    assign o_sts.pay_esc  = (pay_byte == sfb_pkg::ESC_BYTE) || (pay_byte == sfb_pkg::FLAG_BYTE);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Select the outgoing word
    always_comb begin
        unique case (i_cmd.sel)
            sfb_pkg::SRC_FLAG:   n_byte = sfb_pkg::FLAG_BYTE;
            sfb_pkg::SRC_HDR:    n_byte = hdr;
            sfb_pkg::SRC_ESC:    n_byte = sfb_pkg::ESC_BYTE;
            sfb_pkg::SRC_PAY:    n_byte = pay_byte;
            sfb_pkg::SRC_PAY_X:  n_byte = pay_byte ^ sfb_pkg::ESC_XOR;
            sfb_pkg::SRC_CRC_LO: n_byte = r_crc[7:0];
            sfb_pkg::SRC_CRC_HI: n_byte = r_crc[15:8];
            default:             n_byte = sfb_pkg::FLAG_BYTE;
        endcase
    end

    // Write the payload store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_store[r_fill[sfb_pkg::PAY_IDX_W-1:0]] <= i_char_in;
        end
    end

    // Advance or clear the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.clr_fill) begin
            r_fill <= '0;
        end else if (i_cmd.store_wr) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // Hold the message type register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_type <= sfb_pkg::MSG_TYPE_RST;
        end else if (i_cfg_wr_en) begin
            r_msg_type <= i_cfg_wr_data;
        end
    end

    // Run the CRC over header, payload and padding
    always_ff @(posedge i_clk) begin
        if (i_cmd.crc_clr) begin
            r_crc <= 16'h0000;
        end else if (i_cmd.crc_upd) begin
            r_crc <= sfb_pkg::crc_update(r_crc, crc_in);
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= n_byte;
            r_end  <= i_cmd.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_byte_out  = r_byte;
    assign o_frame_end = r_end;

endmodule

### rtl/serial_frame_builder_crc16_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_builder_crc16_unit
// Buffers characters and sends each line, or each full payload, as a CRC-16
// protected, byte-stuffed frame.
//
//   port group   direction  handshake               payload
//   in           input      i_in_valid/o_in_ready   i_char_in
//   out          output     o_out_valid/i_out_ready o_byte_out, o_frame_end
//   cfg          input      i_cfg_wr_en             i_cfg_wr_data
//
// A character that does not close a frame is only stored. A closing one
// starts a flush of 13 + PAYLOAD_SIZE + (escaped bytes) words, one per cycle
// while the sink is ready; the sequencer sets that pace, one word per step.
// Input is held off for the whole flush. A stalled sink holds the sequencer.
// Reset is synchronous; the block takes words in the first cycle after it.
// ----------------------------------------------------------------------------
module serial_frame_builder_crc16_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_byte_out,
    output logic       o_frame_end,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    sfb_pkg::t_cmd cmd;
    sfb_pkg::t_sts sts;

    // Sequencer
    sfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    sfb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_char_in     (i_char_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_byte_out    (o_byte_out),
        .o_frame_end   (o_frame_end)
    );

`ifndef NO_ASSERTIONS
    // Never load a word over one that is still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> sts.out_free)
        else $error("word loaded while output register busy");

    // No input taken while a frame is going out
    a_no_accept_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !(i_in_valid && o_in_ready))
        else $error("input accepted during flush");

    // Closing word is always the flag
    a_end_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_byte_out == sfb_pkg::FLAG_BYTE))
        else $error("frame end on a non-flag word");

    // After the end flag is loaded, the block is ready for input
    a_end_then_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && cmd.frame_end) |=> o_in_ready)
        else $error("not ready after frame end");
`endif

endmodule
